@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define GQTL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define GQTL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/gqtl_pkg.sv @@
package gqtl_pkg;

   localparam int unsigned GLYPH_SLOTS_DEF = 128;

   // field widths
   localparam int CODE_W   = 8;
   localparam int TEXEL_W  = 16;
   localparam int OFFSET_W = 20;
   localparam int LEN_W    = 19;
   localparam int SCALE_W  = 16;
   localparam int ORIGIN_W = 24;
   localparam int COORD_W  = 32;
   localparam int LINE_W   = 16;

   // csr port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ASCENT       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_ADVANCE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_CODE   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_COUNT  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRAW_ENABLE  = 3'd7;

   localparam logic FUNC_CHAR   = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;
   localparam logic KIND_QUAD   = 1'b0;
   localparam logic KIND_EXTENT = 1'b1;

   localparam logic [CODE_W-1:0] CODE_NEWLINE  = 8'd10;
   localparam logic [CODE_W-1:0] CODE_FALLBACK = 8'd63;

   localparam logic [30:0] PEN_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [TEXEL_W-1:0]         atlas_left;
      logic [TEXEL_W-1:0]         atlas_top;
      logic [TEXEL_W-1:0]         atlas_right;
      logic [TEXEL_W-1:0]         atlas_bottom;
      logic signed [OFFSET_W-1:0] offset_left;
      logic signed [OFFSET_W-1:0] offset_right;
      logic signed [OFFSET_W-1:0] offset_top;
      logic signed [OFFSET_W-1:0] offset_bottom;
      logic [LEN_W-1:0]           advance;
   } glyph_entry_type;

   // micro-ops of the shared multiplier
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LINE_PREV,
      OP_LINE,
      OP_LIN_HI,
      OP_LIN_LO,
      OP_ASCENT,
      OP_OFF_L,
      OP_OFF_R,
      OP_OFF_T,
      OP_OFF_B,
      OP_ADV
   } mul_op_type;

   typedef enum logic [1:0] {
      PROG_QUAD,
      PROG_ADV,
      PROG_EXT
   } prog_type;

   // steps of a program; the step after the last issues nothing
   function automatic logic [3:0] prog_len(prog_type prog);
      logic [3:0] len;
      unique case (prog)
         PROG_QUAD: len = 4'd9;
         PROG_ADV:  len = 4'd1;
         PROG_EXT:  len = 4'd5;
         default:   len = 4'd1;
      endcase
      return len;
   endfunction

   function automatic mul_op_type prog_op(prog_type prog, logic [3:0] step);
      mul_op_type op;
      op = OP_NONE;
      unique case (prog)
         PROG_QUAD: begin
            case (step)
               4'd0:    op = OP_LINE_PREV;
               4'd1:    op = OP_OFF_L;
               4'd2:    op = OP_LIN_HI;
               4'd3:    op = OP_LIN_LO;
               4'd4:    op = OP_OFF_R;
               4'd5:    op = OP_ASCENT;
               4'd6:    op = OP_OFF_T;
               4'd7:    op = OP_OFF_B;
               4'd8:    op = OP_ADV;
               default: op = OP_NONE;
            endcase
         end
         PROG_ADV: begin
            if (step == 4'd0) op = OP_ADV;
         end
         PROG_EXT: begin
            case (step)
               4'd0:    op = OP_LINE;
               4'd2:    op = OP_LIN_HI;
               4'd3:    op = OP_LIN_LO;
               default: op = OP_NONE;
            endcase
         end
         default: op = OP_NONE;
      endcase
      return op;
   endfunction

   // clamp to the signed 32-bit coordinate range
   function automatic logic [COORD_W-1:0] sat32(logic signed [47:0] v);
      logic [COORD_W-1:0] r;
      if (v > 48'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (v < -48'sd2147483648) r = 32'h8000_0000;
      else                           r = v[COORD_W-1:0];
      return r;
   endfunction

endpackage

@@ hdl/gqtl_req_if.sv @@
interface gqtl_req_if import gqtl_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [CODE_W-1:0]          code;
   logic                       last;
   logic [TEXEL_W-1:0]         atlas_left;
   logic [TEXEL_W-1:0]         atlas_top;
   logic [TEXEL_W-1:0]         atlas_right;
   logic [TEXEL_W-1:0]         atlas_bottom;
   logic signed [OFFSET_W-1:0] offset_left;
   logic signed [OFFSET_W-1:0] offset_top;
   logic signed [OFFSET_W-1:0] offset_right;
   logic signed [OFFSET_W-1:0] offset_bottom;
   logic [LEN_W-1:0]           advance;

   modport source (
      output valid, func, code, last, atlas_left, atlas_top, atlas_right, atlas_bottom,
             offset_left, offset_top, offset_right, offset_bottom, advance,
      input  ready
   );
   modport sink (
      input  valid, func, code, last, atlas_left, atlas_top, atlas_right, atlas_bottom,
             offset_left, offset_top, offset_right, offset_bottom, advance,
      output ready
   );
endinterface

@@ hdl/gqtl_rsp_if.sv @@
interface gqtl_rsp_if import gqtl_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic signed [COORD_W-1:0] screen_x0;
   logic signed [COORD_W-1:0] screen_y0;
   logic signed [COORD_W-1:0] screen_x1;
   logic signed [COORD_W-1:0] screen_y1;
   logic [TEXEL_W-1:0]        tex_left;
   logic [TEXEL_W-1:0]        tex_top;
   logic [TEXEL_W-1:0]        tex_right;
   logic [TEXEL_W-1:0]        tex_bottom;
   logic                      run_end;

   modport source (
      output valid, kind, screen_x0, screen_y0, screen_x1, screen_y1,
             tex_left, tex_top, tex_right, tex_bottom, run_end,
      input  ready
   );
   modport sink (
      input  valid, kind, screen_x0, screen_y0, screen_x1, screen_y1,
             tex_left, tex_top, tex_right, tex_bottom, run_end,
      output ready
   );
endinterface

@@ hdl/gqtl_ram.sv @@
module gqtl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/glyph_quad_text_layout_core.sv @@
// Load item: writes the glyph slot its code names when the code is below GLYPH_SLOTS; no result.
// Newline or missing glyph: no table read. Drawn glyph: table read, quad program, then its quad;
// measured only: table read and advance. Extent adds its own program. One 21x20 multiplier does all.
// Only one item is in flight; req ready is low until all its results are taken.
// Synchronous active-high reset: config to defaults, pen 0, widest 0, line 1;
// the glyph table is not cleared and holds garbage until loaded.
`include "assert_macros.svh"

module glyph_quad_text_layout_core import gqtl_pkg::*; #(
   parameter int unsigned GLYPH_SLOTS = GLYPH_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   gqtl_req_if.sink               req_chan,
   gqtl_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned SLOT_W  = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
   localparam int unsigned ENTRY_W = $bits(glyph_entry_type);
   localparam logic [8:0]  SLOTS_9 = 9'(GLYPH_SLOTS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_RUN,
      S_OUT
   } state_type;

   // ---------------------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------------------
   state_type state_ff, state_in;
   prog_type  prog_ff, prog_in;
   logic [3:0] step_ff, step_in;
   logic       last_ff, last_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   // multiplier product and the op that made it
   mul_op_type         op_ff, op_in;
   logic signed [40:0] prod_ff, prod_in;

   // working values
   logic [34:0]          lin_ff, lin_in;         // line number (line - 1 for a quad) times line advance
   logic signed [47:0]   acc_ff, acc_in;         // baseline (with origin_y) or height
   logic signed [32:0]   pen_org_ff, pen_org_in; // origin_x + pen
   logic [COORD_W-1:0]   x0_ff, x0_in, y0_ff, y0_in, x1_ff, x1_in, y1_ff, y1_in;

   // layout walk
   logic [30:0]       pen_ff, pen_in;
   logic [30:0]       widest_ff, widest_in;
   logic [LINE_W-1:0] line_ff, line_in;

   // configuration
   logic [SCALE_W-1:0]         scale_ff, scale_in;
   logic [LEN_W-1:0]           ascent_ff, ascent_in;
   logic [LEN_W-1:0]           line_adv_ff, line_adv_in;
   logic signed [ORIGIN_W-1:0] origin_x_ff, origin_x_in;
   logic signed [ORIGIN_W-1:0] origin_y_ff, origin_y_in;
   logic [CODE_W-1:0]          first_code_ff, first_code_in;
   logic [CODE_W-1:0]          glyph_count_ff, glyph_count_in;
   logic                       draw_ff, draw_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [COORD_W-1:0] rsp_x0_ff, rsp_x0_in, rsp_y0_ff, rsp_y0_in;
   logic [COORD_W-1:0] rsp_x1_ff, rsp_x1_in, rsp_y1_ff, rsp_y1_in;
   logic [TEXEL_W-1:0] rsp_tl_ff, rsp_tl_in, rsp_tt_ff, rsp_tt_in;
   logic [TEXEL_W-1:0] rsp_tr_ff, rsp_tr_in, rsp_tb_ff, rsp_tb_in;
   logic               rsp_end_ff, rsp_end_in;

   // ---------------------------------------------------------------------------------
   // combinational helpers
   // ---------------------------------------------------------------------------------
   logic               req_fire, rsp_fire;
   logic [8:0]         code_9, first_9, count_9, end_9, cp_9, idx_9;
   logic               hit;
   logic               ram_we;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   glyph_entry_type    wr_entry, glyph;
   mul_op_type         op_cur;
   logic signed [20:0] mul_a;
   logic [18:0]        mul_b;
   logic signed [32:0] sc;
   logic [33:0]        pen_sum;
   logic [30:0]        width_max;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;

   // glyph lookup; codes outside the loaded range fall back to '?'
   always_comb begin
      code_9  = {1'b0, req_chan.code};
      first_9 = {1'b0, first_code_ff};
      count_9 = {1'b0, glyph_count_ff};
      end_9   = first_9 + count_9;
      cp_9    = ((code_9 < first_9) || (code_9 >= end_9)) ? {1'b0, CODE_FALLBACK} : code_9;
      idx_9   = cp_9 - first_9;
      hit     = (cp_9 >= first_9) && (idx_9 < count_9) && (idx_9 < SLOTS_9);
   end

   // glyph table
   always_comb begin
      wr_entry.atlas_left    = req_chan.atlas_left;
      wr_entry.atlas_top     = req_chan.atlas_top;
      wr_entry.atlas_right   = req_chan.atlas_right;
      wr_entry.atlas_bottom  = req_chan.atlas_bottom;
      wr_entry.offset_left   = req_chan.offset_left;
      wr_entry.offset_right  = req_chan.offset_right;
      wr_entry.offset_top    = req_chan.offset_top;
      wr_entry.offset_bottom = req_chan.offset_bottom;
      wr_entry.advance       = req_chan.advance;
      ram_wdata = wr_entry;
      ram_we    = req_fire && (req_chan.func == FUNC_LOAD) && (code_9 < SLOTS_9);
      glyph     = glyph_entry_type'(ram_rdata);
   end

   gqtl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (GLYPH_SLOTS)
   ) u_glyph_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_chan.code[SLOT_W-1:0]),
      .wdata (ram_wdata),
      .raddr (slot_ff),
      .rdata (ram_rdata)
   );

   // shared multiplier operand select
   always_comb begin
      op_cur = (state_ff == S_RUN) ? prog_op(prog_ff, step_ff) : OP_NONE;
      mul_a  = '0;
      mul_b  = {3'b000, scale_ff};
      case (op_cur)
         OP_LINE_PREV: begin
            mul_a = $signed({5'b00000, line_ff - 16'd1});
            mul_b = line_adv_ff;
         end
         OP_LINE: begin
            mul_a = $signed({5'b00000, line_ff});
            mul_b = line_adv_ff;
         end
         OP_LIN_HI: mul_a = $signed({2'b00, lin_ff[34:16]});
         OP_LIN_LO: mul_a = $signed({5'b00000, lin_ff[15:0]});
         OP_ASCENT: mul_a = $signed({2'b00, ascent_ff});
         OP_OFF_L:  mul_a = 21'(glyph.offset_left);
         OP_OFF_R:  mul_a = 21'(glyph.offset_right);
         OP_OFF_T:  mul_a = 21'(glyph.offset_top);
         OP_OFF_B:  mul_a = 21'(glyph.offset_bottom);
         OP_ADV:    mul_a = $signed({2'b00, glyph.advance});
         default:   mul_a = '0;
      endcase
   end

   // floor(product / 256)
   assign sc        = $signed(prod_ff[40:8]);
   assign pen_sum   = {3'b000, pen_ff} + {1'b0, sc[32:0]};
   assign width_max = (pen_ff > widest_ff) ? pen_ff : widest_ff;

   // ---------------------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------------------
   always_comb begin
      state_in       = state_ff;
      prog_in        = prog_ff;
      step_in        = step_ff;
      last_in        = last_ff;
      slot_in        = slot_ff;
      op_in          = op_cur;
      prod_in        = mul_a * $signed({1'b0, mul_b});
      lin_in         = lin_ff;
      acc_in         = acc_ff;
      pen_org_in     = pen_org_ff;
      x0_in          = x0_ff;
      y0_in          = y0_ff;
      x1_in          = x1_ff;
      y1_in          = y1_ff;
      pen_in         = pen_ff;
      widest_in      = widest_ff;
      line_in        = line_ff;
      scale_in       = scale_ff;
      ascent_in      = ascent_ff;
      line_adv_in    = line_adv_ff;
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      first_code_in  = first_code_ff;
      glyph_count_in = glyph_count_ff;
      draw_in        = draw_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_x0_in      = rsp_x0_ff;
      rsp_y0_in      = rsp_y0_ff;
      rsp_x1_in      = rsp_x1_ff;
      rsp_y1_in      = rsp_y1_ff;
      rsp_tl_in      = rsp_tl_ff;
      rsp_tt_in      = rsp_tt_ff;
      rsp_tr_in      = rsp_tr_ff;
      rsp_tb_in      = rsp_tb_ff;
      rsp_end_in     = rsp_end_ff;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE:        scale_in       = csr_wdata[SCALE_W-1:0];
            CSR_ASCENT:       ascent_in      = csr_wdata[LEN_W-1:0];
            CSR_LINE_ADVANCE: line_adv_in    = csr_wdata[LEN_W-1:0];
            CSR_ORIGIN_X:     origin_x_in    = $signed(csr_wdata[ORIGIN_W-1:0]);
            CSR_ORIGIN_Y:     origin_y_in    = $signed(csr_wdata[ORIGIN_W-1:0]);
            CSR_FIRST_CODE:   first_code_in  = csr_wdata[CODE_W-1:0];
            CSR_GLYPH_COUNT:  glyph_count_in = csr_wdata[CODE_W-1:0];
            CSR_DRAW_ENABLE:  draw_in        = csr_wdata[0];
         endcase
      end

      // retire the product issued last cycle
      case (op_ff) inside
         OP_LINE_PREV, OP_LINE: lin_in = prod_ff[34:0];
         OP_LIN_HI:             acc_in = acc_ff + (48'(prod_ff) <<< 8);
         OP_LIN_LO, OP_ASCENT:  acc_in = acc_ff + 48'(sc);
         OP_OFF_L:              x0_in  = sat32(48'(pen_org_ff) + 48'(sc));
         OP_OFF_R:              x1_in  = sat32(48'(pen_org_ff) + 48'(sc));
         OP_OFF_T:              y0_in  = sat32(acc_ff + 48'(sc));
         OP_OFF_B:              y1_in  = sat32(acc_ff + 48'(sc));
         OP_ADV:                pen_in = (pen_sum > {3'b000, PEN_MAX}) ? PEN_MAX
                                                                        : pen_sum[30:0];
         default: ;
      endcase

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_chan.func == FUNC_CHAR)) begin
               last_in = req_chan.last;
               if (req_chan.code == CODE_NEWLINE) begin
                  widest_in = width_max;
                  pen_in    = '0;
                  if (line_ff != {LINE_W{1'b1}}) line_in = line_ff + 16'd1;
                  if (req_chan.last) begin
                     prog_in  = PROG_EXT;
                     step_in  = '0;
                     acc_in   = '0;
                     state_in = S_RUN;
                  end
               end else if (hit) begin
                  slot_in  = idx_9[SLOT_W-1:0];
                  prog_in  = draw_ff ? PROG_QUAD : PROG_ADV;
                  state_in = S_READ;
               end else if (req_chan.last) begin
                  prog_in  = PROG_EXT;
                  step_in  = '0;
                  acc_in   = '0;
                  state_in = S_RUN;
               end
            end
         end
         S_READ: begin
            // table entry shows up next cycle
            pen_org_in = 33'(origin_x_ff) + $signed({2'b00, pen_ff});
            acc_in     = 48'(origin_y_ff);
            step_in    = '0;
            state_in   = S_RUN;
         end
         S_RUN: begin
            step_in = step_ff + 4'd1;
            if (step_ff == prog_len(prog_ff)) begin
               case (prog_ff)
                  PROG_QUAD: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_QUAD;
                     rsp_x0_in    = x0_ff;
                     rsp_y0_in    = y0_ff;
                     rsp_x1_in    = x1_ff;
                     rsp_y1_in    = y1_ff;
                     rsp_tl_in    = glyph.atlas_left;
                     rsp_tt_in    = glyph.atlas_top;
                     rsp_tr_in    = glyph.atlas_right;
                     rsp_tb_in    = glyph.atlas_bottom;
                     rsp_end_in   = !last_ff;
                     state_in     = S_OUT;
                  end
                  PROG_ADV: begin
                     if (last_ff) begin
                        prog_in = PROG_EXT;
                        step_in = '0;
                        acc_in  = '0;
                     end else begin
                        state_in = S_IDLE;
                     end
                  end
                  default: begin
                     // extent closes the string and rearms the walk
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_EXTENT;
                     rsp_x0_in    = '0;
                     rsp_y0_in    = '0;
                     rsp_x1_in    = (glyph_count_ff == '0) ? '0 : {1'b0, width_max};
                     rsp_y1_in    = (glyph_count_ff == '0) ? '0 : sat32(acc_ff);
                     rsp_tl_in    = '0;
                     rsp_tt_in    = '0;
                     rsp_tr_in    = '0;
                     rsp_tb_in    = '0;
                     rsp_end_in   = 1'b1;
                     pen_in       = '0;
                     widest_in    = '0;
                     line_in      = 16'd1;
                     state_in     = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if ((rsp_kind_ff == KIND_QUAD) && last_ff) begin
                  prog_in  = PROG_EXT;
                  step_in  = '0;
                  acc_in   = '0;
                  state_in = S_RUN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   // ---------------------------------------------------------------------------------
   // state and registered outputs
   // ---------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         prog_ff        <= PROG_ADV;
         step_ff        <= '0;
         last_ff        <= 1'b0;
         op_ff          <= OP_NONE;
         pen_ff         <= '0;
         widest_ff      <= '0;
         line_ff        <= 16'd1;
         scale_ff       <= 16'd256;
         ascent_ff      <= 19'd1792;
         line_adv_ff    <= 19'd2304;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         first_code_ff  <= 8'd32;
         glyph_count_ff <= 8'd95;
         draw_ff        <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         prog_ff        <= prog_in;
         step_ff        <= step_in;
         last_ff        <= last_in;
         op_ff          <= op_in;
         pen_ff         <= pen_in;
         widest_ff      <= widest_in;
         line_ff        <= line_in;
         scale_ff       <= scale_in;
         ascent_ff      <= ascent_in;
         line_adv_ff    <= line_adv_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
         first_code_ff  <= first_code_in;
         glyph_count_ff <= glyph_count_in;
         draw_ff        <= draw_in;
         rsp_valid_ff   <= rsp_valid_in;
         // datapath, no reset needed
         slot_ff        <= slot_in;
         prod_ff        <= prod_in;
         lin_ff         <= lin_in;
         acc_ff         <= acc_in;
         pen_org_ff     <= pen_org_in;
         x0_ff          <= x0_in;
         y0_ff          <= y0_in;
         x1_ff          <= x1_in;
         y1_ff          <= y1_in;
         rsp_kind_ff    <= rsp_kind_in;
         rsp_x0_ff      <= rsp_x0_in;
         rsp_y0_ff      <= rsp_y0_in;
         rsp_x1_ff      <= rsp_x1_in;
         rsp_y1_ff      <= rsp_y1_in;
         rsp_tl_ff      <= rsp_tl_in;
         rsp_tt_ff      <= rsp_tt_in;
         rsp_tr_ff      <= rsp_tr_in;
         rsp_tb_ff      <= rsp_tb_in;
         rsp_end_ff     <= rsp_end_in;
      end
   end

   // ports
   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_kind_ff;
   assign rsp_chan.screen_x0  = $signed(rsp_x0_ff);
   assign rsp_chan.screen_y0  = $signed(rsp_y0_ff);
   assign rsp_chan.screen_x1  = $signed(rsp_x1_ff);
   assign rsp_chan.screen_y1  = $signed(rsp_y1_ff);
   assign rsp_chan.tex_left   = rsp_tl_ff;
   assign rsp_chan.tex_top    = rsp_tt_ff;
   assign rsp_chan.tex_right  = rsp_tr_ff;
   assign rsp_chan.tex_bottom = rsp_tb_ff;
   assign rsp_chan.run_end    = rsp_end_ff;

   // ---------------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------------
   `GQTL_ASSERT_ALWAYS(a_no_take_while_result, rsp_valid_ff |-> !req_chan.ready,
      "item taken while a result waits")
   `GQTL_ASSERT(a_step_bound, (state_ff == S_RUN) |-> (step_ff <= prog_len(prog_ff)),
      "sequencer ran past its program")
   `GQTL_ASSERT(a_extent_rearms,
      (rsp_fire && (rsp_kind_ff == KIND_EXTENT)) |=> ((pen_ff == '0) && (line_ff == 16'd1)),
      "walk not rearmed after extent")
   `GQTL_ASSERT(a_open_run_is_quad, (rsp_valid_ff && !rsp_end_ff) |-> (rsp_kind_ff == KIND_QUAD),
      "extent must close the run")

endmodule
